[sv/skvt_pkg.sv]
package skvt_pkg;

  localparam int KeyWidth   = 32;
  localparam int ValueWidth = 32;
  localparam int OccWidth   = 7;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]                   mode;
    logic signed [KeyWidth-1:0]   key;
    logic [ValueWidth-1:0]        value;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [ValueWidth-1:0] value_res;
    logic [OccWidth-1:0]   occupancy;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_UP_CHK,
    S_UP_WR,
    S_MATCH,
    S_DN_CHK,
    S_DN_WR,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RD_MID,
    RD_IM1,
    RD_I,
    RD_P
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_NEW
  } wr_sel_t;

  typedef enum logic [2:0] {
    I_HOLD,
    I_FROM_COUNT,
    I_FROM_P1,
    I_DEC,
    I_INC
  } i_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic       ld_req;
    logic       srch_step;
    rd_sel_t    rd_sel;
    wr_sel_t    wr_sel;
    i_op_t      i_op;
    cnt_op_t    cnt_op;
    logic       st_load;
    logic [1:0] st_code;
    logic       val_load;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       srch_active;
    logic       p_lt_count;
    logic       key_match;
    logic       up_more;
    logic       dn_more;
    logic       out_free;
  } ctrl_stat_t;

endpackage

[sv/sorted_key_value_table_unit.sv]
// sorted key and value table: up to TABLE_DEPTH pairs held in one RAM with
// a read port and a write port, in ascending signed key order. each request
// item is an insert, a find or a remove and gives exactly one result item
// carrying status, the found value (zero unless a find hit) and the occupancy
// afterwards. duplicate keys are kept, a new one placed after its equals;
// find and remove act on the lowest placed match. mode 3 is a no-op. the
// table needs no clearing after reset, only the entry count is cleared.
// timing: one item at a time. the RAM gives one read and one write per
// cycle. after acceptance a request passes a start step and s binary
// search probes, each a read and a compare, s being up to ceil(log2(n+1))
// for n entries. a find or remove whose search stops inside the table then
// checks the candidate entry. an insert, or a remove that hits, then moves
// up to n entries, each by a read and a write, plus a step to place the new
// pair or close the gap. a full-table insert or unused mode goes straight
// to the finish step. a result that is not taken holds the request in its
// last step until the output register frees. the result sits in an output
// register, so the next item is taken while an earlier result waits

module sorted_key_value_table_unit
  import skvt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  // request channel
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  // result channel
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  // command and status between sequencer and datapath
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // sequencer: search, shift and result hand-off
  skvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: table RAM, search bounds, shift index, count, result register
  skvt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

[sv/skvt_ram.sv]
module skvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/skvt_ctrl.sv]
module skvt_ctrl
  import skvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    cmd          = '0;
    cmd.rd_sel   = RD_MID;
    cmd.wr_sel   = WR_NONE;
    cmd.i_op     = I_HOLD;
    cmd.cnt_op   = CNT_HOLD;
    cmd.st_code  = ST_DONE;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.ld_req = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.mode == MODE_INSERT) begin
          if (stat.full) begin
            cmd.st_load = 1'b1;
            cmd.st_code = ST_FULL;
            state_next  = S_FINISH;
          end else begin
            state_next = S_SRCH_RD;
          end
        end else if (stat.mode == MODE_FIND || stat.mode == MODE_REMOVE) begin
          state_next = S_SRCH_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SRCH_RD: begin
        if (stat.srch_active) begin
          cmd.rd_sel = RD_MID;
          state_next = S_SRCH_CMP;
        end else if (stat.mode == MODE_INSERT) begin
          cmd.i_op   = I_FROM_COUNT;
          state_next = S_UP_CHK;
        end else if (stat.p_lt_count) begin
          cmd.rd_sel = RD_P;
          state_next = S_MATCH;
        end else begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_NOT_FOUND;
          state_next  = S_FINISH;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_step = 1'b1;
        state_next    = S_SRCH_RD;
      end
      S_UP_CHK: begin
        if (stat.up_more) begin
          cmd.rd_sel = RD_IM1;
          state_next = S_UP_WR;
        end else begin
          cmd.wr_sel = WR_NEW;
          cmd.cnt_op = CNT_INC;
          state_next = S_FINISH;
        end
      end
      S_UP_WR: begin
        cmd.wr_sel = WR_UP;
        cmd.i_op   = I_DEC;
        state_next = S_UP_CHK;
      end
      S_MATCH: begin
        if (!stat.key_match) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_NOT_FOUND;
          state_next  = S_FINISH;
        end else if (stat.mode == MODE_FIND) begin
          cmd.val_load = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.i_op   = I_FROM_P1;
          state_next = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        if (stat.dn_more) begin
          cmd.rd_sel = RD_I;
          state_next = S_DN_WR;
        end else begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_FINISH;
        end
      end
      S_DN_WR: begin
        cmd.wr_sel = WR_DOWN;
        cmd.i_op   = I_INC;
        state_next = S_DN_CHK;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[sv/skvt_dp.sv]
module skvt_dp
  import skvt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  ctrl_cmd_t  cmd,
  output ctrl_stat_t stat,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = KeyWidth + ValueWidth;

  req_t                  req_q;
  logic [CW-1:0]         count;
  logic [CW-1:0]         lo;
  logic [CW-1:0]         hi;
  logic [CW-1:0]         idx;
  logic [1:0]            st;
  logic [ValueWidth-1:0] val;

  logic [CW-1:0]         mid;
  logic [CW-1:0]         idx_m1;
  logic [CW-1:0]         lo_p1;
  logic                  go_right;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [EW-1:0]         ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [EW-1:0]         ram_rdata;
  logic signed [KeyWidth-1:0] rd_key;
  logic [ValueWidth-1:0] rd_value;

  skvt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key   = $signed(ram_rdata[EW-1:ValueWidth]);
  assign rd_value = ram_rdata[ValueWidth-1:0];

  assign mid    = lo + ((hi - lo) >> 1);
  assign idx_m1 = idx - CW'(1);
  assign lo_p1  = lo + CW'(1);

  // insert probes for the upper bound, find and remove for the lower bound
  always_comb begin
    if (req_q.mode == MODE_INSERT) begin
      go_right = !(req_q.key < rd_key);
    end else begin
      go_right = rd_key < req_q.key;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_MID:  ram_raddr = mid[AW-1:0];
      RD_IM1:  ram_raddr = idx_m1[AW-1:0];
      RD_I:    ram_raddr = idx[AW-1:0];
      RD_P:    ram_raddr = lo[AW-1:0];
      default: ram_raddr = lo[AW-1:0];
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = ram_rdata;
    case (cmd.wr_sel)
      WR_UP: begin
        ram_we    = 1'b1;
        ram_waddr = idx[AW-1:0];
      end
      WR_DOWN: begin
        ram_we    = 1'b1;
        ram_waddr = idx_m1[AW-1:0];
      end
      WR_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = lo[AW-1:0];
        ram_wdata = {req_q.key, req_q.value};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        CNT_INC: count <= count + CW'(1);
        CNT_DEC: count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      req_q <= req;
      lo    <= '0;
      hi    <= count;
      st    <= ST_DONE;
      val   <= '0;
    end else begin
      if (cmd.srch_step) begin
        if (go_right) begin
          lo <= mid + CW'(1);
        end else begin
          hi <= mid;
        end
      end
      if (cmd.st_load) begin
        st <= cmd.st_code;
      end
      if (cmd.val_load) begin
        val <= rd_value;
      end
    end
    case (cmd.i_op)
      I_FROM_COUNT: idx <= count;
      I_FROM_P1:    idx <= lo_p1;
      I_DEC:        idx <= idx_m1;
      I_INC:        idx <= idx + CW'(1);
      default:      idx <= idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.status    <= st;
      res.value_res <= val;
      res.occupancy <= OccWidth'(count);
    end
  end

  always_comb begin
    stat.mode        = req_q.mode;
    stat.full        = count == CW'(TABLE_DEPTH);
    stat.srch_active = lo < hi;
    stat.p_lt_count  = lo < count;
    stat.key_match   = rd_key == req_q.key;
    stat.up_more     = idx > lo;
    stat.dn_more     = idx < count;
    stat.out_free    = !res_valid || res_ready;
  end

endmodule

[tb/skvt_tb_pkg.sv]
`timescale 1ns / 100ps

package skvt_tb_pkg;
  import skvt_pkg::*;

  localparam int TableDepth = 64;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // keeps its own sorted copy of the table and the result items it implies
  class table_mirror;
    logic signed [KeyWidth-1:0] keys [TableDepth];
    logic [ValueWidth-1:0]      vals [TableDepth];
    int unsigned held;
    res_t        pending_results [$];
    int unsigned mismatches;
    int unsigned stored, refused, hits, misses, removed, ignored, peak;

    function void note_request(input req_t item);
      res_t outcome;
      int   pos;
      int   i;
      outcome = '0;
      outcome.status = ST_DONE;
      pos = 0;
      case (item.mode)
        MODE_INSERT: begin
          if (held >= TableDepth) begin
            outcome.status = ST_FULL;
            refused++;
          end else begin
            // new pair lands after every key less than or equal to it
            while (pos < held && keys[pos] <= $signed(item.key)) pos++;
            for (i = held; i > pos; i--) begin
              keys[i] = keys[i-1];
              vals[i] = vals[i-1];
            end
            keys[pos] = item.key;
            vals[pos] = item.value;
            held++;
            stored++;
            if (held > peak) peak = held;
          end
        end
        MODE_FIND, MODE_REMOVE: begin
          // first placed entry not below the key
          while (pos < held && keys[pos] < $signed(item.key)) pos++;
          if (pos >= held || keys[pos] != $signed(item.key)) begin
            outcome.status = ST_NOT_FOUND;
            misses++;
          end else if (item.mode == MODE_FIND) begin
            outcome.value_res = vals[pos];
            hits++;
          end else begin
            for (i = pos + 1; i < held; i++) begin
              keys[i-1] = keys[i];
              vals[i-1] = vals[i];
            end
            held--;
            removed++;
          end
        end
        default: ignored++;
      endcase
      outcome.occupancy = OccWidth'(held);
      pending_results.push_back(outcome);
    endfunction

    function void check_result(input res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result item: status %0d value_res %h occupancy %0d",
               got.status, got.value_res, got.occupancy);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          mismatches++;
        end
        if (got.value_res !== want.value_res) begin
          $error("value_res: expected %h, actual %h", want.value_res, got.value_res);
          mismatches++;
        end
        if (got.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
          mismatches++;
        end
      end
    endfunction
  endclass

endpackage

[tb/sorted_key_value_table_unit_test.sv]
`timescale 1ns / 100ps

module sorted_key_value_table_unit_test;
  import skvt_pkg::*;
  import skvt_tb_pkg::*;

  localparam int PhaseItems = 284;   // random items in each idling phase
  localparam int HoldCycles = 600;   // long back-pressure stretch
  localparam int HoldAfter  = 620;   // results seen before the hold-off starts
  localparam int DrainWait  = 200;   // beyond the slowest request

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic res_valid;
  logic res_ready;
  res_t res;

  table_mirror mirror = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned results_seen;
  bit          hold_done;

  // random stimulus steering: fill up to full, then drain back to empty
  bit          filling;
  int unsigned full_tries;
  logic signed [KeyWidth-1:0] key_pool [12];

  sorted_key_value_table_unit #(
    .TABLE_DEPTH(TableDepth)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // offer one request item, idling first at the current sender rate;
  // entered and left at a falling edge
  task automatic send_item(input req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    mirror.note_request(item);
    @(negedge clk);
  endtask

  task automatic offer(input logic [1:0] mode, input logic signed [KeyWidth-1:0] key,
                       input logic [ValueWidth-1:0] value);
    req_t item;
    item.mode  = mode;
    item.key   = key;
    item.value = value;
    send_item(item);
  endtask

  // weighted random request: mostly keys already held or from a small pool
  // so that finds and removes hit, plus full range keys for every bit
  function automatic req_t random_request();
    req_t        item;
    int unsigned pick;
    int unsigned src;
    pick = $urandom_range(99);
    if (pick < 3)
      item.mode = MODE_UNUSED;
    else if (pick < 18)
      item.mode = MODE_FIND;
    else if (filling)
      item.mode = (pick < 30) ? MODE_REMOVE : MODE_INSERT;
    else
      item.mode = (pick < 38) ? MODE_INSERT : MODE_REMOVE;
    src = $urandom_range(99);
    if (src < 55 && mirror.held > 0)
      item.key = mirror.keys[$urandom_range(mirror.held - 1)];
    else if (src < 80)
      item.key = key_pool[$urandom_range(11)];
    else
      item.key = $urandom();
    item.value = $urandom();
    return item;
  endfunction

  task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    req_t item;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (PhaseItems) begin
      // turn round once full has been reported a few times, or when empty
      if (filling && mirror.held >= TableDepth && full_tries >= 3) begin
        filling    = 1'b0;
        full_tries = 0;
      end else if (!filling && mirror.held == 0) begin
        filling = 1'b1;
      end
      item = random_request();
      if (item.mode == MODE_INSERT && mirror.held >= TableDepth) full_tries++;
      send_item(item);
    end
  endtask

  // result side: random stalls, and once a long hold-off so the block
  // backs up and stops taking request items
  initial begin : result_sink
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HoldAfter) begin
        res_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // every accepted result item is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      mirror.check_result(res);
      results_seen++;
    end
  end

  initial begin : stimulus
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    filling    = 1'b1;
    full_tries = 0;
    key_pool   = '{32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd0, 32'sd1, 32'sd2,
                   -32'sd2, 32'sd100, -32'sd100, 32'sh4000_0000, 32'sh1234_5678,
                   32'shc000_0000};
    send_idle_pct = 37;
    recv_idle_pct = 81;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty table lookups and the unused mode
    offer(MODE_FIND,   32'sd0, 32'h0);
    offer(MODE_REMOVE, 32'sd0, 32'hffff_ffff);
    offer(MODE_UNUSED, 32'sd0, 32'h0);
    // key and value extremes, and duplicates of zero
    offer(MODE_INSERT, 32'sd0,          32'hffff_ffff);
    offer(MODE_INSERT, 32'sh7fff_ffff,  32'h0);
    offer(MODE_INSERT, 32'sh8000_0000,  32'ha5a5_a5a5);
    offer(MODE_INSERT, -32'sd1,         32'h0000_0001);
    offer(MODE_INSERT, 32'sd0,          32'h0000_0002);
    offer(MODE_INSERT, 32'sd0,          32'h0000_0003);
    // find gives the first of equal keys
    offer(MODE_FIND,   32'sd0,          32'h1234_5678);
    offer(MODE_FIND,   32'sh8000_0000,  32'h0);
    offer(MODE_FIND,   32'sh7fff_ffff,  32'h0);
    offer(MODE_FIND,   -32'sd1,         32'h0);
    offer(MODE_FIND,   32'sd1,          32'h0);
    // remove the first duplicate, then the ends
    offer(MODE_REMOVE, 32'sd0,          32'h0);
    offer(MODE_FIND,   32'sd0,          32'h0);
    offer(MODE_REMOVE, 32'sh7fff_ffff,  32'h0);
    offer(MODE_REMOVE, 32'sh8000_0000,  32'h0);
    offer(MODE_UNUSED, 32'sh5a5a_5a5a,  32'hffff_ffff);
    offer(MODE_REMOVE, 32'sd5,          32'h0);
    offer(MODE_INSERT, 32'sh5a5a_5a5a,  32'h5a5a_5a5a);
    offer(MODE_FIND,   32'sh5a5a_5a5a,  32'h0);
    offer(MODE_FIND,   -32'sd1,         32'hffff_ffff);

    // random: slow receiver, then slow sender, then no idling
    random_phase(37, 81);
    random_phase(81, 37);
    random_phase(0, 0);
    req_valid <= 1'b0;

    while (mirror.pending_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("covered %0d stored, %0d full refusals, %0d find hits, %0d removes,",
             mirror.stored, mirror.refused, mirror.hits, mirror.removed);
    $display("  %0d misses, %0d unused-mode items, peak occupancy %0d",
             mirror.misses, mirror.ignored, mirror.peak);
    if (mirror.mismatches == 0)
      $display("sorted_key_value_table_unit regression: pass");
    else
      $display("sorted_key_value_table_unit regression: fail");
    $finish;
  end

  // watchdog well beyond the slowest correct run
  initial begin : watchdog
    #(5_000_000);
    $display("sorted_key_value_table_unit regression: fail");
    $finish;
  end

endmodule
